/* src/nfmn_pkg.sv */
// Shared types and constants for the nearest free mesh node search.
package nfmn_pkg;

  // Coordinates cover meshes of up to 16 by 16 processors.
  localparam int unsigned CrdW  = 4;
  localparam int unsigned DistW = 5;
  localparam int unsigned DimW  = 5;

  typedef logic [CrdW-1:0]  crd_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [DimW-1:0]  dim_t;

  // Request function codes.
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncMap   = 1'b1;

  // Configuration register indexes.
  localparam logic RegCols = 1'b0;
  localparam logic RegRows = 1'b1;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic  vld;
    logic  srch;
    logic  fnd;
    dist_t hops;
    crd_t  x;
    crd_t  y;
  } tok_t;

  // Broadcast context for every cell: master, mesh size and table write.
  typedef struct packed {
    crd_t mst_x;
    crd_t mst_y;
    dim_t cols;
    dim_t rows;
    logic wr_en;
    crd_t wr_x;
    crd_t wr_y;
    logic wr_free;
  } ctl_t;

  // Finished search result.
  typedef struct packed {
    logic fnd;
    crd_t x;
    crd_t y;
  } res_t;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StHold
  } state_e;

endpackage

/* src/nfmn_cell.sv */
// One mesh processor cell: holds its free flag and refines the passing search token.
module nfmn_cell #(
  parameter int unsigned CELL_X = 0,
  parameter int unsigned CELL_Y = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nfmn_pkg::ctl_t ctl_i,
  input  nfmn_pkg::tok_t tok_i,
  output nfmn_pkg::tok_t tok_o
);
  import nfmn_pkg::*;

  localparam crd_t CX       = crd_t'(CELL_X);
  localparam crd_t CY       = crd_t'(CELL_Y);
  localparam logic IsOrigin = (CELL_X == 0) && (CELL_Y == 0);

  logic  free_q, free_d;
  crd_t  dx, dy;
  dist_t hops;
  logic  in_mesh, is_mst, elig, better;
  tok_t  tok_d, tok_q;

  // Manhattan distance from the master.
  always_comb begin
    dx   = (ctl_i.mst_x > CX) ? (ctl_i.mst_x - CX) : (CX - ctl_i.mst_x);
    dy   = (ctl_i.mst_y > CY) ? (ctl_i.mst_y - CY) : (CY - ctl_i.mst_y);
    hops = {1'b0, dx} + {1'b0, dy};
  end

  // A cell competes when it is free, inside the mesh, not the master and not the origin.
  always_comb begin
    in_mesh = ({1'b0, CX} < ctl_i.cols) && ({1'b0, CY} < ctl_i.rows);
    is_mst  = (CX == ctl_i.mst_x) && (CY == ctl_i.mst_y);
    elig    = free_q && in_mesh && !is_mst && !IsOrigin;
    // Order is nearer ring first, then lower column, then upper row.
    better  = !tok_i.fnd || (hops < tok_i.hops) ||
              ((hops == tok_i.hops) &&
               ((CX < tok_i.x) || ((CX == tok_i.x) && (CY > tok_i.y))));
  end

  // Token update.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && tok_i.srch && elig && better) begin
      tok_d.fnd  = 1'b1;
      tok_d.hops = hops;
      tok_d.x    = CX;
      tok_d.y    = CY;
    end
  end

  // Free flag write from an update request.
  always_comb begin
    free_d = free_q;
    if (ctl_i.wr_en && (ctl_i.wr_x == CX) && (ctl_i.wr_y == CY)) begin
      free_d = ctl_i.wr_free;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      free_q <= free_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* src/nfmn_cfg.sv */
// Configuration registers for the mesh size, with clamped effective dimensions.
module nfmn_cfg #(
  parameter int unsigned MESH_MAX_COLS = 8,
  parameter int unsigned MESH_MAX_ROWS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output nfmn_pkg::dim_t       cols_o,
  output nfmn_pkg::dim_t       rows_o
);
  import nfmn_pkg::*;

  localparam dim_t MaxCols = dim_t'(MESH_MAX_COLS);
  localparam dim_t MaxRows = dim_t'(MESH_MAX_ROWS);

  logic [3:0] cols_q, cols_d, rows_q, rows_d;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (wr) begin
      unique case (paddr[2])
        RegCols: cols_d = pwdata[3:0];
        RegRows: rows_d = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 4'd8;
      rows_q <= 4'd8;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[2])
      RegCols: prdata = {28'd0, cols_q};
      RegRows: prdata = {28'd0, rows_q};
      default: prdata = '0;
    endcase
  end

  // Effective dimensions: zero acts as one, values above the maximum act as the maximum.
  always_comb begin
    if (cols_q == 4'd0) begin
      cols_o = dim_t'(1);
    end else if ({1'b0, cols_q} > MaxCols) begin
      cols_o = MaxCols;
    end else begin
      cols_o = {1'b0, cols_q};
    end
    if (rows_q == 4'd0) begin
      rows_o = dim_t'(1);
    end else if ({1'b0, rows_q} > MaxRows) begin
      rows_o = MaxRows;
    end else begin
      rows_o = {1'b0, rows_q};
    end
  end

endmodule

/* src/nearest_free_mesh_node_search.sv */
// Top level: request control, cell chain and result output for the nearest free node search.
// An update request is accepted back to back while no search is running.
// A map request sweeps a token through one cell per processor, one cell a cycle: its result is
// registered for output once the token leaves the end of the chain.
// No new request is accepted until that result is registered in the output register.
// Reset clears every free flag, sets both dimension registers to 8 and empties the output.
module nearest_free_mesh_node_search #(
  parameter int unsigned MESH_MAX_COLS = 8,
  parameter int unsigned MESH_MAX_ROWS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: node_x [2:0], node_y [5:3], page_count [13:6], zero [15:14].
  input  logic [15:0] s_axis_tdata,
  // tuser: func [0].
  input  logic        s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: chosen_x [2:0], chosen_y [5:3], zero [7:6].
  output logic [7:0]  m_axis_tdata,
  // tuser: found [0].
  output logic        m_axis_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nfmn_pkg::*;

  localparam int unsigned Nodes = MESH_MAX_COLS * MESH_MAX_ROWS;

  state_e state_q, state_d;
  dim_t   cols, rows;
  crd_t   in_x, in_y;
  logic   in_mesh, acc, out_free;
  logic   ld_srch, ld_hold, ld_out_hold;
  crd_t   mst_x_q, mst_x_d, mst_y_q, mst_y_d;
  tok_t   lau_q, lau_d;
  ctl_t   ctl;
  tok_t   tok [Nodes+1];
  tok_t   end_tok;
  res_t   hold_q, hold_d, out_q, out_d;
  logic   out_vld_q, out_vld_d;

  nfmn_cfg #(
    .MESH_MAX_COLS(MESH_MAX_COLS),
    .MESH_MAX_ROWS(MESH_MAX_ROWS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cols_o (cols),
    .rows_o (rows)
  );

  // Request decode.
  assign in_x    = {1'b0, s_axis_tdata[2:0]};
  assign in_y    = {1'b0, s_axis_tdata[5:3]};
  assign in_mesh = ({1'b0, in_x} < cols) && ({1'b0, in_y} < rows);
  assign acc     = s_axis_tvalid && s_axis_tready;

  // Context broadcast to all cells.
  always_comb begin
    ctl.mst_x   = mst_x_q;
    ctl.mst_y   = mst_y_q;
    ctl.cols    = cols;
    ctl.rows    = rows;
    ctl.wr_en   = acc && (s_axis_tuser == FuncWrite) && in_mesh;
    ctl.wr_x    = in_x;
    ctl.wr_y    = in_y;
    ctl.wr_free = (s_axis_tdata[13:6] != 8'd0);
  end

  // Token launch and master capture on a map request.
  always_comb begin
    lau_d   = '0;
    mst_x_d = mst_x_q;
    mst_y_d = mst_y_q;
    if (acc && (s_axis_tuser == FuncMap)) begin
      lau_d.vld  = 1'b1;
      lau_d.srch = in_mesh;
      mst_x_d    = in_x;
      mst_y_d    = in_y;
    end
  end

  // Cell chain, visited in ascending column then ascending row.
  assign tok[0] = lau_q;
  for (genvar gi = 0; gi < Nodes; gi++) begin : g_cell
    nfmn_cell #(
      .CELL_X(gi / MESH_MAX_ROWS),
      .CELL_Y(gi % MESH_MAX_ROWS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .tok_i (tok[gi]),
      .tok_o (tok[gi+1])
    );
  end
  assign end_tok = tok[Nodes];

  assign out_free = !out_vld_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (acc && (s_axis_tuser == FuncMap)) state_d = StSearch;
      end
      StSearch: begin
        if (end_tok.vld) state_d = out_free ? StIdle : StHold;
      end
      StHold: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    ld_srch       = 1'b0;
    ld_hold       = 1'b0;
    ld_out_hold   = 1'b0;
    unique case (state_q)
      StIdle:   s_axis_tready = 1'b1;
      StSearch: begin
        ld_srch = end_tok.vld && out_free;
        ld_hold = end_tok.vld && !out_free;
      end
      StHold:   ld_out_hold = out_free;
      default:  ;
    endcase
  end

  // Result hold and output register.
  always_comb begin
    hold_d    = hold_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    if (ld_hold) begin
      hold_d = '{fnd: end_tok.fnd, x: end_tok.x, y: end_tok.y};
    end
    if (ld_srch) begin
      out_d     = '{fnd: end_tok.fnd, x: end_tok.x, y: end_tok.y};
      out_vld_d = 1'b1;
    end else if (ld_out_hold) begin
      out_d     = hold_q;
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      lau_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lau_q     <= lau_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mst_x_q <= mst_x_d;
    mst_y_q <= mst_y_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.fnd;
  assign m_axis_tdata  = {2'b00, out_q.y[2:0], out_q.x[2:0]};

  // A result appears only at the end of a search.
  a_out_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) != StIdle)
    else $error("result appeared without a search");

  // A launched token always belongs to a running search.
  a_launch_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lau_q.vld |-> state_q == StSearch)
    else $error("token launched outside a search");

  // The token leaves the chain only while the search is still running.
  a_end_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_tok.vld |-> state_q == StSearch)
    else $error("token left the chain outside a search");

  // A held result means the output register is still occupied.
  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StHold |-> out_vld_q)
    else $error("result held while the output is empty");

  // A not-found result carries zero coordinates.
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.fnd) |-> (out_q.x == '0) && (out_q.y == '0))
    else $error("not-found result with nonzero coordinates");

endmodule
